// ===== hdl/prcd_pkg.sv =====
// ----------------------------------------------------------------------------
// prcd_pkg
// Shared types and constants of the paired-end reverse-complement diff encoder:
// register indexes, element and result codes, base characters and the
// complement table.
// ----------------------------------------------------------------------------
package prcd_pkg;

  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 11;
  localparam int POS_W   = 10;
  localparam int CNT_W   = 11;
  localparam int MIS_W   = 12;
  localparam int CNT_MAX = 2047;

  typedef enum logic [CFG_AW-1:0] {
    REG_ENABLE         = 2'd0,
    REG_MIN_OVERLAP    = 2'd1,
    REG_DIFF_THRESHOLD = 2'd2
  } reg_index_t;

  localparam logic FUNC_READ1   = 1'b0;
  localparam logic FUNC_READ2   = 1'b1;
  localparam logic KIND_DIFF    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UC = 8'h43;
  localparam logic [7:0] CH_UG = 8'h47;
  localparam logic [7:0] CH_UN = 8'h4E;
  localparam logic [7:0] CH_UT = 8'h54;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LC = 8'h63;
  localparam logic [7:0] CH_LG = 8'h67;
  localparam logic [7:0] CH_LN = 8'h6E;
  localparam logic [7:0] CH_LT = 8'h74;

  function automatic logic [7:0] complement_of(input logic [7:0] b);
    logic [7:0] c;
    unique case (b)
      CH_UA:   c = CH_UT;
      CH_UC:   c = CH_UG;
      CH_UG:   c = CH_UC;
      CH_UT:   c = CH_UA;
      CH_LA:   c = CH_LT;
      CH_LC:   c = CH_LG;
      CH_LG:   c = CH_LC;
      CH_LT:   c = CH_LA;
      CH_LN:   c = CH_LN;
      default: c = CH_UN;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/pe_read_revcomp_diff_encoder.sv =====
// ----------------------------------------------------------------------------
// pe_read_revcomp_diff_encoder
// Path: a diff passes stage 1 and then the result register; a verdict also passes stage 2.
// Throughput: one element per cycle while busy is low; busy holds for one cycle after read 2's last
// element, since that element's diff and verdict share one result register.
// Reset: synchronous; clears pair state, counters and the strobe, loads enable 1,
// min_overlap 0, diff_threshold 0; the read-1 buffer is not cleared.
// ----------------------------------------------------------------------------
module pe_read_revcomp_diff_encoder
  import prcd_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     func,
  input  logic [7:0]               base,
  input  logic [7:0]               quality,
  input  logic                     last,
  input  logic                     cfg_wr_en,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_DW-1:0]        cfg_wdata,
  output logic                     result_valid,
  output logic                     kind,
  output logic [POS_W-1:0]         position,
  output logic [7:0]               diff_base,
  output logic signed [7:0]        qual_delta,
  output logic                     beneficial,
  output logic [CNT_W-1:0]         diff_count,
  output logic                     overflow,
  output logic                     run_last
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int MW = (LW > CFG_DW) ? LW : CFG_DW;
  localparam int SW = ((LW > MIS_W) ? LW : MIS_W) + 1;

  // configuration
  logic              enable;
  logic [CFG_DW-1:0] min_overlap;
  logic [CFG_DW-1:0] diff_threshold;

  // pair state, updated at the transaction
  logic [LW-1:0] r1_length, r1_length_next;
  logic [LW-1:0] r2_position, r2_position_next;
  logic          reading_second, reading_second_next;
  logic          overflow_seen, overflow_seen_next;

  // read-1 buffer: {base, quality}
  logic [15:0]   r1_mem [MAX_LEN];
  logic [15:0]   rd_word;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic          accept;
  logic [LW-1:0] len_base;
  logic          ovf_base;
  logic          store_ok;
  logic          in_range;
  logic          has_r1;

  // stage 1
  logic             s1_valid;
  logic             s1_r2;
  logic             s1_last;
  logic             s1_in_range;
  logic             s1_has_r1;
  logic [POS_W-1:0] s1_pos;
  logic [7:0]       s1_base;
  logic [7:0]       s1_qual;
  logic [LW-1:0]    s1_len1;
  logic [LW-1:0]    s1_len2;
  logic             s1_ovf;
  logic             s1_mism;
  logic             s1_diff;
  logic [7:0]       s1_qd;
  logic [LW-1:0]    s1_shorter;
  logic [LW-1:0]    s1_len_diff;
  logic             s1_verdict;

  logic [MIS_W-1:0] mismatch_count;

  // stage 2
  logic             s2_valid;
  logic             s2_ovf;
  logic             s2_len_ok;
  logic [LW-1:0]    s2_len_diff;
  logic [SW-1:0]    s2_sum;
  logic             s2_over;
  logic [CNT_W-1:0] s2_cnt;
  logic             s2_ben;

  assign busy   = rst | (s1_valid & s1_r2 & s1_last);
  assign accept = start & ~busy;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b1;
      min_overlap    <= '0;
      diff_threshold <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_ENABLE:         enable         <= cfg_wdata[0];
        REG_MIN_OVERLAP:    min_overlap    <= cfg_wdata;
        REG_DIFF_THRESHOLD: diff_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // transaction stage: pair bookkeeping and buffer addressing
  always_comb begin
    len_base            = reading_second ? '0 : r1_length;
    ovf_base            = reading_second ? 1'b0 : overflow_seen;
    store_ok            = len_base < LW'(MAX_LEN);
    in_range            = r2_position < LW'(MAX_LEN);
    has_r1              = r2_position < r1_length;
    wr_en               = 1'b0;
    rd_addr             = AW'(r1_length - r2_position - LW'(1));
    r1_length_next      = r1_length;
    r2_position_next    = r2_position;
    reading_second_next = reading_second;
    overflow_seen_next  = overflow_seen;
    if (func == FUNC_READ1) begin
      wr_en               = store_ok;
      r1_length_next      = len_base + LW'(store_ok);
      r2_position_next    = '0;
      overflow_seen_next  = ovf_base | ~store_ok;
      reading_second_next = last;
    end else if (last) begin
      r1_length_next      = '0;
      r2_position_next    = '0;
      overflow_seen_next  = 1'b0;
      reading_second_next = 1'b0;
    end else begin
      r2_position_next    = r2_position + LW'(in_range);
      overflow_seen_next  = overflow_seen | ~in_range;
      reading_second_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_length      <= '0;
      r2_position    <= '0;
      reading_second <= 1'b0;
      overflow_seen  <= 1'b0;
    end else if (accept) begin
      r1_length      <= r1_length_next;
      r2_position    <= r2_position_next;
      reading_second <= reading_second_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      r1_mem[AW'(len_base)] <= {base, quality};
    end
    rd_word <= r1_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_r2       <= (func == FUNC_READ2);
    s1_last     <= last;
    s1_in_range <= in_range;
    s1_has_r1   <= has_r1;
    s1_pos      <= POS_W'(r2_position);
    s1_base     <= base;
    s1_qual     <= quality;
    s1_len1     <= r1_length;
    s1_len2     <= r2_position + LW'(in_range);
    s1_ovf      <= overflow_seen | ~in_range;
  end

  // stage 1: compare against the complemented read-1 base
  always_comb begin
    s1_mism     = s1_has_r1 && (complement_of(rd_word[15:8]) != s1_base);
    s1_diff     = s1_valid && s1_r2 && s1_in_range && enable && (!s1_has_r1 || s1_mism);
    s1_qd       = s1_has_r1 ? (s1_qual - rd_word[7:0]) : 8'd0;
    s1_shorter  = (s1_len1 < s1_len2) ? s1_len1 : s1_len2;
    s1_len_diff = (s1_len1 > s1_len2) ? (s1_len1 - s1_len2) : (s1_len2 - s1_len1);
    s1_verdict  = s1_valid && s1_r2 && s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_count <= '0;
    end else if (s2_valid) begin
      mismatch_count <= '0;
    end else if (s1_valid) begin
      if (!s1_r2) begin
        mismatch_count <= '0;
      end else if (s1_in_range && s1_mism &&
                   mismatch_count <= MIS_W'(diff_threshold)) begin
        mismatch_count <= mismatch_count + MIS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_verdict;
    end
  end

  always_ff @(posedge clk) begin
    s2_ovf      <= s1_ovf;
    s2_len_ok   <= MW'(s1_shorter) >= MW'(min_overlap);
    s2_len_diff <= s1_len_diff;
  end

  // stage 2: verdict
  always_comb begin
    s2_over = mismatch_count > MIS_W'(diff_threshold);
    s2_sum  = SW'(mismatch_count) + SW'(s2_len_diff);
    s2_cnt  = '0;
    s2_ben  = 1'b0;
    if (enable && s2_len_ok) begin
      if (s2_over) begin
        s2_cnt = (mismatch_count > MIS_W'(CNT_MAX)) ? CNT_W'(CNT_MAX)
                                                     : CNT_W'(mismatch_count);
      end else begin
        s2_cnt = (s2_sum > SW'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(s2_sum);
        s2_ben = (s2_sum <= SW'(diff_threshold)) && !s2_ovf;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s2_valid | s1_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      kind       <= KIND_VERDICT;
      position   <= '0;
      diff_base  <= '0;
      qual_delta <= '0;
      beneficial <= s2_ben;
      diff_count <= s2_cnt;
      overflow   <= s2_ovf;
      run_last   <= 1'b1;
    end else begin
      kind       <= KIND_DIFF;
      position   <= s1_pos;
      diff_base  <= s1_base;
      qual_delta <= s1_qd;
      beneficial <= 1'b0;
      diff_count <= '0;
      overflow   <= 1'b0;
      run_last   <= ~s1_last;
    end
  end

  a_no_slot_clash: assert property (@(posedge clk) disable iff (rst)
    !(s2_valid && s1_diff))
    else $error("diff and verdict compete for the result register");

  a_verdict_follows_last: assert property (@(posedge clk) disable iff (rst)
    s1_verdict |-> !accept ##1 s2_valid)
    else $error("verdict stage not loaded after last read-2 transaction");

  a_verdict_closes_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_VERDICT |-> run_last && position == '0)
    else $error("verdict result malformed");

  a_mismatch_cleared: assert property (@(posedge clk) disable iff (rst)
    s2_valid |=> mismatch_count == '0)
    else $error("mismatch count not cleared after verdict");

endmodule

// ===== sim/prcd_checker.sv =====
// ----------------------------------------------------------------------------
// prcd_checker
// Watches the element, register and result channels of the read-pair
// reverse-complement diff encoder, keeps its own copy of read 1 and of the
// pair state, works out the diff and verdict records owed for each accepted
// element and compares every strobed result with the oldest record owed.
// ----------------------------------------------------------------------------
module prcd_checker
  import prcd_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 func,
  input  logic [7:0]           base,
  input  logic [7:0]           quality,
  input  logic                 last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  input  logic                 result_valid,
  input  logic                 kind,
  input  logic [POS_W-1:0]     position,
  input  logic [7:0]           diff_base,
  input  logic signed [7:0]    qual_delta,
  input  logic                 beneficial,
  input  logic [CNT_W-1:0]     diff_count,
  input  logic                 overflow,
  input  logic                 run_last,
  output int                   fail_count,
  output int                   owed
);

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [7:0]       diff_base;
    logic [7:0]       qual_delta;
    logic             beneficial;
    logic [CNT_W-1:0] diff_count;
    logic             overflow;
    logic             run_last;
  } record_t;

  record_t    owed_records[$];
  logic [7:0] read1_bases [0:MAX_LEN-1];
  logic [7:0] read1_quals [0:MAX_LEN-1];
  int         read1_len;
  int         read2_pos;
  int         mismatches;
  logic       on_read2;
  logic       too_long;
  logic       encode_on;
  int         min_overlap;
  int         threshold;

  function automatic logic [7:0] paired_base(input logic [7:0] b);
    case (b)
      CH_UA:   return CH_UT;
      CH_UT:   return CH_UA;
      CH_UC:   return CH_UG;
      CH_UG:   return CH_UC;
      CH_LA:   return CH_LT;
      CH_LT:   return CH_LA;
      CH_LC:   return CH_LG;
      CH_LG:   return CH_LC;
      CH_LN:   return CH_LN;
      default: return CH_UN;
    endcase
  endfunction

  task automatic clear_pair();
    read1_len  = 0;
    read2_pos  = 0;
    mismatches = 0;
    on_read2   = 1'b0;
    too_long   = 1'b0;
  endtask

  task automatic owe(input record_t rec);
    owed_records.insert(owed_records.size(), rec);
  endtask

  task automatic encode_element(input logic f, input logic [7:0] b, input logic [7:0] q,
                                input logic l);
    record_t    diff_rec;
    record_t    verdict_rec;
    logic       has_diff;
    logic       mism;
    logic [7:0] qd;
    int         j;
    int         shorter;
    int         gap;
    int         cnt;
    logic       good;
    has_diff    = 1'b0;
    diff_rec    = '0;
    verdict_rec = '0;
    if (f == FUNC_READ1) begin
      if (on_read2) clear_pair();
      if (read1_len < MAX_LEN) begin
        read1_bases[read1_len] = b;
        read1_quals[read1_len] = q;
        read1_len++;
      end else begin
        too_long = 1'b1;
      end
      if (l) on_read2 = 1'b1;
    end else begin
      on_read2 = 1'b1;
      if (read2_pos < MAX_LEN) begin
        qd = 8'd0;
        if (read2_pos < read1_len) begin
          j    = read1_len - 1 - read2_pos;
          mism = paired_base(read1_bases[j]) != b;
          if (mism) begin
            if (mismatches <= threshold) mismatches++;
            qd = q - read1_quals[j];
          end
        end else begin
          mism = 1'b1;
        end
        if (mism && encode_on) begin
          has_diff           = 1'b1;
          diff_rec.kind      = KIND_DIFF;
          diff_rec.position  = POS_W'(read2_pos);
          diff_rec.diff_base = b;
          diff_rec.qual_delta = qd;
        end
        read2_pos++;
      end else begin
        too_long = 1'b1;
      end
      if (l) begin
        shorter = (read1_len < read2_pos) ? read1_len : read2_pos;
        gap     = (read1_len > read2_pos) ? read1_len - read2_pos : read2_pos - read1_len;
        cnt     = 0;
        good    = 1'b0;
        if (encode_on && shorter >= min_overlap) begin
          if (mismatches > threshold) begin
            cnt = mismatches;
          end else begin
            cnt  = mismatches + gap;
            good = (cnt <= threshold) && !too_long;
          end
          if (cnt > CNT_MAX) cnt = CNT_MAX;
        end
        verdict_rec.kind       = KIND_VERDICT;
        verdict_rec.beneficial = good;
        verdict_rec.diff_count = CNT_W'(cnt);
        verdict_rec.overflow   = too_long;
        verdict_rec.run_last   = 1'b1;
        clear_pair();
        if (has_diff) owe(diff_rec);
        owe(verdict_rec);
      end else if (has_diff) begin
        diff_rec.run_last = 1'b1;
        owe(diff_rec);
      end
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    record_t e;
    if (rst) begin
      fail_count  = 0;
      encode_on   = 1'b1;
      min_overlap = 0;
      threshold   = 0;
      clear_pair();
      owed_records.delete();
    end else begin
      if (result_valid) begin
        if (owed_records.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual kind %0d position %0d",
                   $time, kind, position);
        end else begin
          e = owed_records.pop_front();
          compare_field("kind", e.kind, kind);
          compare_field("position", e.position, position);
          compare_field("diff_base", e.diff_base, diff_base);
          compare_field("qual_delta", $signed(e.qual_delta), qual_delta);
          compare_field("beneficial", e.beneficial, beneficial);
          compare_field("diff_count", e.diff_count, diff_count);
          compare_field("overflow", e.overflow, overflow);
          compare_field("run_last", e.run_last, run_last);
        end
      end
      if (start && !busy) encode_element(func, base, quality, last);
      if (cfg_wr_en) begin
        case (reg_index_t'(cfg_addr))
          REG_ENABLE:         encode_on   = cfg_wdata[0];
          REG_MIN_OVERLAP:    min_overlap = int'(cfg_wdata);
          REG_DIFF_THRESHOLD: threshold   = int'(cfg_wdata);
          default: ;
        endcase
      end
    end
    owed <= owed_records.size();
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives read pairs into the reverse-complement diff encoder: a short directed
// pair set covering every base code, wrapping quality deltas, bases beyond
// read 1, an abandoned pair and an unterminated read 1, then random pairs
// (mostly well formed, some broken) over several register settings including
// the extremes. Bursty element pacing; the checker alongside the encoder
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import prcd_pkg::*;

  localparam int DEPTH = 1024;
  localparam int LIMIT = 300000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  func;
  logic [7:0]            base;
  logic [7:0]            quality;
  logic                  last;
  logic                  cfg_wr_en;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [CFG_DW-1:0]     cfg_wdata;
  logic                  result_valid;
  logic                  kind;
  logic [POS_W-1:0]      position;
  logic [7:0]            diff_base;
  logic signed [7:0]     qual_delta;
  logic                  beneficial;
  logic [CNT_W-1:0]      diff_count;
  logic                  overflow;
  logic                  run_last;
  int                    fail_count;
  int                    owed;
  int                    cycles = 0;
  int                    burst_left = 0;
  int                    elements_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pe_read_revcomp_diff_encoder #(.MAX_LEN(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .base(base),
    .quality(quality), .last(last), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .result_valid(result_valid), .kind(kind),
    .position(position), .diff_base(diff_base), .qual_delta(qual_delta),
    .beneficial(beneficial), .diff_count(diff_count), .overflow(overflow),
    .run_last(run_last)
  );

  prcd_checker #(.MAX_LEN(DEPTH)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .base(base),
    .quality(quality), .last(last), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .result_valid(result_valid), .kind(kind),
    .position(position), .diff_base(diff_base), .qual_delta(qual_delta),
    .beneficial(beneficial), .diff_count(diff_count), .overflow(overflow),
    .run_last(run_last), .fail_count(fail_count), .owed(owed)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 12))
      0:       return CH_UA;
      1:       return CH_UC;
      2:       return CH_UG;
      3:       return CH_UT;
      4:       return CH_UN;
      5:       return CH_LA;
      6:       return CH_LC;
      7:       return CH_LG;
      8:       return CH_LT;
      9:       return CH_LN;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
      end
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
  endtask

  task automatic send_elem(input logic f, input logic [7:0] b, input logic [7:0] q,
                           input logic l);
    pace();
    @(negedge clk);
    start   <= 1'b1;
    func    <= f;
    base    <= b;
    quality <= q;
    last    <= l;
    do @(posedge clk); while (busy);
    elements_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DW-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
  endtask

  task automatic set_regs(input logic en, input int mino, input int thr);
    settle();
    write_reg(REG_ENABLE, CFG_DW'(en));
    write_reg(REG_MIN_OVERLAP, CFG_DW'(mino));
    write_reg(REG_DIFF_THRESHOLD, CFG_DW'(thr));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // read 2 follows the reverse complement of read 1 except at err_pct percent
  task automatic send_pair(input int len1, input int len2, input bit close1,
                           input bit close2, input int err_pct);
    logic [7:0] kept[$];
    logic [7:0] b;
    int         stored;
    int         i;
    for (i = 0; i < len1; i++) begin
      b = pick_base();
      send_elem(FUNC_READ1, b, 8'($urandom), close1 && (i == len1 - 1));
      if (i < DEPTH) kept.insert(kept.size(), b);
    end
    stored = kept.size();
    for (i = 0; i < len2; i++) begin
      if (i < stored && $urandom_range(0, 99) >= err_pct) b = complement_of(kept[stored - 1 - i]);
      else b = pick_base();
      send_elem(FUNC_READ2, b, 8'($urandom), close2 && (i == len2 - 1));
    end
  endtask

  task automatic run_directed();
    logic [7:0] r1b [10];
    logic [7:0] r1q [10];
    logic [7:0] b;
    logic [7:0] q;
    int         i;
    r1b = '{CH_UA, CH_UC, CH_UG, CH_UT, CH_LA, CH_LC, CH_LG, CH_LT, CH_LN, 8'hFF};
    r1q = '{8'd33, 8'd74, 8'd0, 8'd40, 8'd128, 8'd127, 8'd1, 8'd255, 8'd90, 8'd60};
    for (i = 0; i < 10; i++) send_elem(FUNC_READ1, r1b[i], r1q[i], i == 9);
    // wrapping deltas at two mismatches, then one base past read 1
    for (i = 0; i < 11; i++) begin
      q = 8'd50;
      if (i == 10) b = CH_UG;
      else b = complement_of(r1b[9 - i]);
      if (i == 2) begin
        b = CH_LG;
        q = 8'd0;
      end
      if (i == 7) begin
        b = CH_UA;
        q = 8'd255;
      end
      send_elem(FUNC_READ2, b, q, i == 10);
    end
    // abandon a pair mid read 2, then a read 2 with read 1 left open
    send_elem(FUNC_READ1, CH_UG, 8'd70, 1'b1);
    send_elem(FUNC_READ2, CH_UC, 8'd70, 1'b0);
    send_elem(FUNC_READ1, CH_UA, 8'd20, 1'b0);
    send_elem(FUNC_READ2, CH_UT, 8'd30, 1'b1);
  endtask

  task automatic run_phase(input int n_items, input int err_max);
    int first;
    int shape;
    int len1;
    int len2;
    first = elements_sent;
    while (elements_sent - first < n_items) begin
      shape = $urandom_range(0, 9);
      len1  = $urandom_range(0, 16);
      len2  = $urandom_range(1, 16);
      if (shape >= 6 && len1 > 0) len2 = len1;
      if (shape == 2) send_pair(len1, len2, 1'b1, 1'b1, 100);
      else send_pair(len1, len2, shape != 0, shape != 1, $urandom_range(0, err_max));
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    func      = FUNC_READ1;
    base      = 8'd0;
    quality   = 8'd0;
    last      = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = REG_ENABLE;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    set_regs(1'b1, 0, 1024);
    run_phase(80, 30);
    set_regs(1'b1, 1024, 0);
    run_phase(50, 30);
    set_regs(1'b0, $urandom_range(0, 1024), $urandom_range(0, 1024));
    run_phase(70, 50);
    set_regs(1'b1, $urandom_range(0, 6), $urandom_range(0, 8));
    run_phase(100, 40);
    set_regs(1'b1, 1024, 1024);
    run_phase(30, 20);
    set_regs(1'b1, $urandom_range(0, 4), $urandom_range(0, 4));
    run_phase(100, 60);
    set_regs(1'b1, $urandom_range(0, 1024), $urandom_range(0, 1024));
    run_phase(70, 20);
    settle();

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
